// File: hw/rtl/rtt_pkg.sv
// ----------------------------------------------------------------------------
// RTT estimator package
// Shared widths, register indexes, config struct and saturation helper.
// ----------------------------------------------------------------------------
package rtt_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned AccW    = 24;
  localparam int unsigned RtoW    = 17;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 1;
  // signed working width for the delta updates
  localparam int unsigned CalcW   = 40;

  localparam logic signed [CalcW-1:0] AccMax = CalcW'(64'd16777215);
  localparam logic signed [CalcW-1:0] RtoMax = CalcW'(64'd131071);

  localparam logic [CfgW-1:0] MinRtoReset = 16'd2;
  localparam logic [CfgW-1:0] MaxRtoReset = 16'd128;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMinRto = 1'b0,
    CfgMaxRto = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CfgW-1:0] min_rto;
    logic [CfgW-1:0] max_rto;
  } cfg_t;

  // floor at 1, saturate at the accumulator maximum
  function automatic logic [AccW-1:0] sat_acc(input logic signed [CalcW-1:0] v);
    logic [AccW-1:0] r;
    if (v[CalcW-1] || (v == '0)) begin
      r = AccW'(1);
    end else if (v > AccMax) begin
      r = AccMax[AccW-1:0];
    end else begin
      r = v[AccW-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/rtt_cfg_regs.sv
// ----------------------------------------------------------------------------
// RTT config registers
// Holds the minimum and maximum retransmit timeout bounds.
// ----------------------------------------------------------------------------
module rtt_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rtt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rtt_pkg::CfgW-1:0]    cfg_wdata_i,
  output rtt_pkg::cfg_t               cfg_o
);

  rtt_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (rtt_pkg::cfg_reg_e'(cfg_idx_i))
        rtt_pkg::CfgMinRto: cfg_d.min_rto = cfg_wdata_i;
        rtt_pkg::CfgMaxRto: cfg_d.max_rto = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_rto <= rtt_pkg::MinRtoReset;
      cfg_q.max_rto <= rtt_pkg::MaxRtoReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/rtt_update.sv
// ----------------------------------------------------------------------------
// RTT update logic
// Seed or delta update of smoothed RTT and variance, and the clamped timeout.
// ----------------------------------------------------------------------------
module rtt_update #(
  parameter int unsigned RTT_SHIFT    = 5,
  parameter int unsigned RTTVAR_SHIFT = 4,
  parameter int unsigned DELTA_SHIFT  = 2,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic [rtt_pkg::SampleW-1:0] rtt_i,
  input  logic [rtt_pkg::AccW-1:0]    srtt_i,
  input  logic [rtt_pkg::AccW-1:0]    rttvar_i,
  input  rtt_pkg::cfg_t               cfg_i,
  output logic [rtt_pkg::AccW-1:0]    srtt_o,
  output logic [rtt_pkg::AccW-1:0]    rttvar_o,
  output logic [rtt_pkg::RtoW-1:0]    rto_o
);

  localparam int unsigned CW    = rtt_pkg::CalcW;
  localparam int unsigned EffW  = (SAMPLE_WIDTH < rtt_pkg::SampleW) ? SAMPLE_WIDTH
                                                                   : rtt_pkg::SampleW;
  localparam logic [rtt_pkg::SampleW-1:0] SampleMask =
    rtt_pkg::SampleW'((64'd1 << EffW) - 64'd1);
  localparam int unsigned SrttRs = RTT_SHIFT - DELTA_SHIFT;
  localparam int VarDiff = int'(RTTVAR_SHIFT) - int'(DELTA_SHIFT);
  localparam int unsigned VarRs = (VarDiff >= 0) ? VarDiff : 0;
  localparam int unsigned VarLs = (VarDiff < 0) ? -VarDiff : 0;

  logic signed [CW-1:0] rtt_s, srtt_w, var_w;
  logic signed [CW-1:0] delta, abs_delta, vdelta;
  logic signed [CW-1:0] seed_srtt, seed_var;
  logic signed [CW-1:0] nsrtt_w, nvar_w, tsum, lo, hi, t;
  logic [rtt_pkg::AccW-1:0] nsrtt, nvar;

  always_comb begin
    rtt_s  = signed'(CW'(rtt_i & SampleMask));
    srtt_w = signed'(CW'(srtt_i));
    var_w  = signed'(CW'(rttvar_i));

    delta     = ((rtt_s - CW'(1)) <<< DELTA_SHIFT) - (srtt_w >>> SrttRs);
    abs_delta = delta[CW-1] ? -delta : delta;
    vdelta    = abs_delta - ((var_w >>> VarRs) <<< VarLs);

    seed_srtt = rtt_s <<< RTT_SHIFT;
    seed_var  = rtt_s <<< (RTTVAR_SHIFT - 1);

    if (srtt_i != '0) begin
      nsrtt = rtt_pkg::sat_acc(srtt_w + delta);
      nvar  = rtt_pkg::sat_acc(var_w + vdelta);
    end else begin
      // first sample seeds both; only the upper bound applies
      nsrtt = (seed_srtt > rtt_pkg::AccMax) ? rtt_pkg::AccMax[rtt_pkg::AccW-1:0]
                                            : seed_srtt[rtt_pkg::AccW-1:0];
      nvar  = (seed_var > rtt_pkg::AccMax) ? rtt_pkg::AccMax[rtt_pkg::AccW-1:0]
                                           : seed_var[rtt_pkg::AccW-1:0];
    end

    nsrtt_w = signed'(CW'(nsrtt));
    nvar_w  = signed'(CW'(nvar));
    tsum    = ((nsrtt_w >>> SrttRs) + nvar_w) >>> DELTA_SHIFT;

    lo = rtt_s + CW'(2);
    if (signed'(CW'(cfg_i.min_rto)) > lo) begin
      lo = signed'(CW'(cfg_i.min_rto));
    end
    hi = signed'(CW'(cfg_i.max_rto));

    if (tsum < lo) begin
      t = lo;
    end else if (tsum > hi) begin
      t = hi;
    end else begin
      t = tsum;
    end
    if (t > rtt_pkg::RtoMax) begin
      t = rtt_pkg::RtoMax;
    end
  end

  assign srtt_o   = nsrtt;
  assign rttvar_o = nvar;
  assign rto_o    = t[rtt_pkg::RtoW-1:0];

endmodule

// File: hw/rtl/rtt_estimator_rto_unit.sv
// ----------------------------------------------------------------------------
// RTT estimator with retransmit timeout
// Input register, single-pass update stage, result register.
// ----------------------------------------------------------------------------
// Sample path: an accepted sample is held in the input register, and the update
// stage writes the result register from it, waiting while that register stalls.
// Throughput: one sample per cycle while out_stall_i is low; the update of the
// srtt/rttvar registers is a single combinational pass between input and result registers.
// Reset: srtt and rttvar clear to zero (no sample yet), min_rto = 2,
// max_rto = 128, both pipeline stages empty.
module rtt_estimator_rto_unit #(
  parameter int unsigned RTT_SHIFT    = 5,
  parameter int unsigned RTTVAR_SHIFT = 4,
  parameter int unsigned DELTA_SHIFT  = 2,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rtt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rtt_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rtt_pkg::SampleW-1:0] rtt_sample_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rtt_pkg::AccW-1:0]    smoothed_rtt_o,
  output logic [rtt_pkg::AccW-1:0]    rtt_variance_o,
  output logic [rtt_pkg::RtoW-1:0]    retransmit_timeout_o
);

  rtt_pkg::cfg_t cfg;

  logic                        in_vld_q, in_vld_d;
  logic [rtt_pkg::SampleW-1:0] rtt_q;
  logic                        out_vld_q, out_vld_d;
  logic [rtt_pkg::AccW-1:0]    srtt_q, rttvar_q;
  logic [rtt_pkg::AccW-1:0]    srtt_res_q, var_res_q;
  logic [rtt_pkg::RtoW-1:0]    rto_q;
  logic [rtt_pkg::AccW-1:0]    srtt_d, rttvar_d;
  logic [rtt_pkg::RtoW-1:0]    rto_d;
  logic                        in_fire, calc_fire;

  rtt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rtt_update #(
    .RTT_SHIFT    (RTT_SHIFT),
    .RTTVAR_SHIFT (RTTVAR_SHIFT),
    .DELTA_SHIFT  (DELTA_SHIFT),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_update (
    .rtt_i    (rtt_q),
    .srtt_i   (srtt_q),
    .rttvar_i (rttvar_q),
    .cfg_i    (cfg),
    .srtt_o   (srtt_d),
    .rttvar_o (rttvar_d),
    .rto_o    (rto_d)
  );

  // advance the update stage whenever the result register is free or draining
  assign calc_fire  = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !calc_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (calc_fire) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = calc_fire || (out_vld_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      srtt_q    <= '0;
      rttvar_q  <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (calc_fire) begin
        srtt_q   <= srtt_d;
        rttvar_q <= rttvar_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rtt_q <= rtt_sample_i;
    end
    if (calc_fire) begin
      srtt_res_q <= srtt_d;
      var_res_q  <= rttvar_d;
      rto_q      <= rto_d;
    end
  end

  assign out_valid_o          = out_vld_q;
  assign smoothed_rtt_o       = srtt_res_q;
  assign rtt_variance_o       = var_res_q;
  assign retransmit_timeout_o = rto_q;

  // once seeded, the smoothed value never returns to zero
  a_srtt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (srtt_q != '0) |=> (srtt_q != '0))
    else $error("smoothed RTT dropped back to zero");

  // a zero smoothed result comes only with a zero variance
  a_seed_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((srtt_res_q == '0) == (var_res_q == '0)))
    else $error("smoothed RTT and variance disagree on seeding");

  // state holds while the update stage is blocked
  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && out_stall_i) |=> ($stable(srtt_q) && $stable(rttvar_q)))
    else $error("state changed while the result register was stalled");

  // input stalls only with a sample waiting in the update stage
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_vld_q))
    else $error("input stalled without a blocked update stage");

endmodule
